[rtl/core/tte_pkg.sv]
// Shared types and constants for the timer table engine.
// Used by tte_slot_eval and timer_table_engine; no dependencies.
package tte_pkg;

	localparam int TIME_BITS = 48;
	localparam int WAIT_W    = 31;
	localparam int ID_W      = 32;

	typedef enum logic [1:0] {
		REQ_START  = 2'd0,
		REQ_CANCEL = 2'd1,
		REQ_TICK   = 2'd2,
		REQ_QUERY  = 2'd3
	} req_kind_t;

	typedef enum logic [2:0] {
		RSP_START  = 3'd0,
		RSP_CANCEL = 3'd1,
		RSP_FIRED  = 3'd2,
		RSP_TICK   = 3'd3,
		RSP_QUERY  = 3'd4
	} rsp_kind_t;

	// One slot of the timer memory
	typedef struct packed {
		logic [ID_W-1:0]      ident;
		logic                 clk_sel;
		logic [TIME_BITS-1:0] due;
		logic [WAIT_W-1:0]    period;
		logic                 reload;
	} slot_entry_t;

	// Evaluation of one slot against the current clocks
	typedef struct packed {
		logic                 fire;
		logic [WAIT_W-1:0]    rem;
		logic [TIME_BITS-1:0] due_next;
	} slot_eval_t;

endpackage

[rtl/core/tte_slot_eval.sv]
// Per-slot time arithmetic: due check, clamped remaining time, reload due.
// Depends on tte_pkg.
module tte_slot_eval (
	input  tte_pkg::slot_entry_t                 entry,
	input  logic [tte_pkg::TIME_BITS-1:0]        mono_now,
	input  logic [tte_pkg::TIME_BITS-1:0]        boot_now,
	output tte_pkg::slot_eval_t                  result
);
	import tte_pkg::*;

	logic [TIME_BITS-1:0] now;
	logic [TIME_BITS:0]   diff;
	logic [TIME_BITS:0]   sum;
	logic                 past;

	assign now  = entry.clk_sel ? boot_now : mono_now;
	assign diff = {1'b0, entry.due} - {1'b0, now};
	assign past = diff[TIME_BITS] || (diff == '0);
	assign sum  = {1'b0, now} + (TIME_BITS+1)'(entry.period);

	always_comb begin
		result.fire = past;
		if (past)
			result.rem = '0;
		else if (|diff[TIME_BITS-1:WAIT_W])
			result.rem = '1;
		else
			result.rem = diff[WAIT_W-1:0];
		// now + period saturates at the top of the time range
		result.due_next = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
	end

endmodule

[rtl/core/timer_table_engine.sv]
// Timer table engine top level: request sequencer, slot memory, output register.
// Depends on tte_pkg and tte_slot_eval.
//
// Every request walks the slot memory one slot per cycle through its single
// synchronous read port, stalling on a firing slot while the sink holds the output.
// Start, cancel and query walk the table once; tick walks it twice (fire, then
// the poll timeout pass). The closing result also waits until the sink has
// taken any earlier result. One request is in flight at a time; s_tready rises
// again once its final result (m_tlast high) has been loaded for output.
module timer_table_engine #(
	parameter int NUM_SLOTS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// timer_id[31:0], delay_ms[63:32], periodic[64], clock_kind[65],
	// handler_present[66], mono_now_ms[114:67], boot_now_ms[162:115], zero pad
	input  logic [167:0] s_tdata,
	// req_type[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// result_id[31:0], success[32], is_active[33], wait_ms[65:34], zero pad
	output logic [71:0]  m_tdata,
	// resp_kind[2:0]
	output logic [2:0]   m_tuser,
	// last_item
	output logic         m_tlast
);
	import tte_pkg::*;

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_SLOTS);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_POLL = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;

	// request held for the whole operation
	req_kind_t            req_q;
	logic [ID_W-1:0]      tid_q;
	logic [WAIT_W-1:0]    delay_q;
	logic                 per_q;
	logic                 clk_sel_q;
	logic                 hnd_q;
	logic [TIME_BITS-1:0] mono_q;
	logic [TIME_BITS-1:0] boot_q;

	logic [ID_W-1:0]      id_cnt_q;
	logic [NUM_SLOTS-1:0] used_q;

	// scan pipeline
	logic [CNT_W-1:0]     idx_q;
	logic                 vld_s1;
	logic [SLOT_W-1:0]    idx_s1;
	slot_entry_t          entry_s1;

	// accumulators
	logic                 hit_q;
	logic                 act_q;
	logic                 free_found_q;
	logic [SLOT_W-1:0]    free_idx_q;
	logic                 best_vld_q;
	logic [WAIT_W-1:0]    best_q;

	// output register
	logic                 m_tvalid_q;
	rsp_kind_t            o_kind_q;
	logic [ID_W-1:0]      o_id_q;
	logic                 o_ok_q;
	logic                 o_act_q;
	logic [31:0]          o_wait_q;
	logic                 o_last_q;

	slot_entry_t          mem [NUM_SLOTS];

	slot_entry_t          eval_in;
	slot_eval_t           ev;
	slot_entry_t          new_entry;
	logic                 scanning;
	logic                 out_free;
	logic                 used_s1;
	logic                 tid_hit;
	logic                 nid_hit;
	logic                 fire_s1;
	logic                 stall_s1;
	logic                 adv;
	logic                 rd_en;
	logic                 scan_done;
	logic                 take_s1;
	logic                 start_ok;
	logic                 done_go;
	logic                 mem_we;
	logic [SLOT_W-1:0]    mem_waddr;
	slot_entry_t          mem_wdata;
	logic [ID_W-1:0]      id_next;
	logic [31:0]          wait_val;
	logic                 accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign scanning = (state_q == ST_SCAN) || (state_q == ST_POLL);

	assign new_entry.ident   = id_cnt_q;
	assign new_entry.clk_sel = clk_sel_q;
	assign new_entry.due     = '0;
	assign new_entry.period  = delay_q;
	assign new_entry.reload  = per_q;

	// the evaluator also computes the due time of a new timer
	assign eval_in = (state_q == ST_DONE) ? new_entry : entry_s1;

	tte_slot_eval u_eval (
		.entry    (eval_in),
		.mono_now (mono_q),
		.boot_now (boot_q),
		.result   (ev)
	);

	assign used_s1  = used_q[idx_s1];
	assign tid_hit  = used_s1 && (tid_q != '0) && (entry_s1.ident == tid_q);
	assign nid_hit  = used_s1 && hnd_q && (entry_s1.ident == id_cnt_q);
	assign fire_s1  = (state_q == ST_SCAN) && (req_q == REQ_TICK) && used_s1 && ev.fire;
	assign stall_s1 = vld_s1 && fire_s1 && !out_free;
	assign adv      = scanning && !stall_s1;
	assign rd_en    = adv && (idx_q != LAST_CNT);
	assign take_s1  = vld_s1 && adv;
	assign scan_done = scanning && !vld_s1 && (idx_q == LAST_CNT);
	assign start_ok = hnd_q && free_found_q;
	assign done_go  = (state_q == ST_DONE) && out_free;
	assign id_next  = (id_cnt_q == '1) ? ID_W'(1) : id_cnt_q + ID_W'(1);
	assign wait_val = best_vld_q ? {1'b0, best_q} : '1;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = entry_s1;
		if (take_s1 && fire_s1 && entry_s1.reload) begin
			mem_we        = 1'b1;
			mem_wdata.due = ev.due_next;
		end else if (done_go && (req_q == REQ_START) && start_ok) begin
			mem_we        = 1'b1;
			mem_waddr     = free_idx_q;
			mem_wdata     = new_entry;
			mem_wdata.due = ev.due_next;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (rd_en)
			entry_s1 <= mem[idx_q[SLOT_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= req_kind_t'(s_tuser);
			tid_q     <= s_tdata[31:0];
			delay_q   <= s_tdata[63] ? '0 : s_tdata[62:32];
			per_q     <= s_tdata[64];
			clk_sel_q <= s_tdata[65];
			hnd_q     <= s_tdata[66];
			mono_q    <= s_tdata[114:67];
			boot_q    <= s_tdata[162:115];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			id_cnt_q     <= ID_W'(1);
			used_q       <= '0;
			idx_q        <= '0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			hit_q        <= 1'b0;
			act_q        <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			best_vld_q   <= 1'b0;
			best_q       <= '0;
		end else begin
			if (adv) begin
				vld_s1 <= rd_en;
				idx_s1 <= idx_q[SLOT_W-1:0];
				if (rd_en)
					idx_q <= idx_q + CNT_W'(1);
			end

			if (take_s1) begin
				if (state_q == ST_SCAN) begin
					unique case (req_q)
						REQ_START: begin
							if (tid_hit || nid_hit)
								used_q[idx_s1] <= 1'b0;
							if ((!used_s1 || tid_hit || nid_hit) && !free_found_q) begin
								free_found_q <= 1'b1;
								free_idx_q   <= idx_s1;
							end
						end
						REQ_CANCEL: begin
							if (tid_hit) begin
								used_q[idx_s1] <= 1'b0;
								hit_q          <= 1'b1;
							end
						end
						REQ_TICK: begin
							if (fire_s1 && !entry_s1.reload)
								used_q[idx_s1] <= 1'b0;
						end
						default: ;
					endcase
				end else begin
					if (tid_hit)
						act_q <= 1'b1;
					if (used_s1 && (!best_vld_q || (ev.rem < best_q))) begin
						best_vld_q <= 1'b1;
						best_q     <= ev.rem;
					end
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q      <= (s_tuser == REQ_QUERY) ? ST_POLL : ST_SCAN;
						idx_q        <= '0;
						vld_s1       <= 1'b0;
						hit_q        <= 1'b0;
						act_q        <= 1'b0;
						free_found_q <= 1'b0;
						best_vld_q   <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						if (req_q == REQ_TICK) begin
							state_q <= ST_POLL;
							idx_q   <= '0;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_POLL: begin
					if (scan_done)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if ((req_q == REQ_START) && start_ok) begin
							used_q[free_idx_q] <= 1'b1;
							id_cnt_q           <= id_next;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register: fired results during the tick pass, closing result at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if ((take_s1 && fire_s1) || done_go)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take_s1 && fire_s1) begin
			o_kind_q <= RSP_FIRED;
			o_id_q   <= entry_s1.ident;
			o_ok_q   <= 1'b0;
			o_act_q  <= 1'b0;
			o_wait_q <= '0;
			o_last_q <= 1'b0;
		end else if (done_go) begin
			o_last_q <= 1'b1;
			o_act_q  <= 1'b0;
			o_ok_q   <= 1'b0;
			o_wait_q <= '0;
			o_id_q   <= tid_q;
			unique case (req_q)
				REQ_START: begin
					o_kind_q <= RSP_START;
					o_id_q   <= start_ok ? id_cnt_q : '0;
					o_ok_q   <= start_ok;
				end
				REQ_CANCEL: begin
					o_kind_q <= RSP_CANCEL;
					o_ok_q   <= hit_q;
				end
				REQ_TICK: begin
					o_kind_q <= RSP_TICK;
					o_id_q   <= '0;
					o_wait_q <= wait_val;
				end
				REQ_QUERY: begin
					o_kind_q <= RSP_QUERY;
					o_act_q  <= act_q;
					o_wait_q <= wait_val;
				end
				default: o_kind_q <= RSP_QUERY;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = o_kind_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = {6'b0, o_wait_q, o_act_q, o_ok_q, o_id_q};

endmodule

[sim/timer_table_engine_checker.sv]
// Scoreboard for the timer table engine: watches the request and result streams,
// keeps its own copy of the slot table and compares every result transfer.
// Depends on tte_pkg.
module timer_table_engine_checker #(
	parameter int NUM_SLOTS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	// timer_id[31:0], delay_ms[63:32], periodic[64], clock_kind[65],
	// handler_present[66], mono_now_ms[114:67], boot_now_ms[162:115], zero pad
	input  logic [167:0] s_tdata,
	// req_type[1:0]
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	// result_id[31:0], success[32], is_active[33], wait_ms[65:34], zero pad
	input  logic [71:0]  m_tdata,
	// resp_kind[2:0]
	input  logic [2:0]   m_tuser,
	// last_item
	input  logic         m_tlast,
	output int           errors,
	output int           pending,
	output int           checked
);
	import tte_pkg::*;

	localparam logic [TIME_BITS-1:0] TIME_TOP = '1;
	localparam logic [TIME_BITS-1:0] WAIT_CAP = 48'd2147483647;

	typedef struct packed {
		rsp_kind_t   kind;
		logic [31:0] id;
		logic        ok;
		logic        active;
		logic [31:0] wait_ms;
		logic        last;
	} timer_resp_t;

	// shadow slot table
	logic                 t_busy     [NUM_SLOTS];
	logic [ID_W-1:0]      t_id       [NUM_SLOTS];
	logic                 t_boot     [NUM_SLOTS];
	logic [TIME_BITS-1:0] t_deadline [NUM_SLOTS];
	logic [WAIT_W-1:0]    t_interval [NUM_SLOTS];
	logic                 t_rearm    [NUM_SLOTS];
	logic [ID_W-1:0]      id_next;

	timer_resp_t resp_q [$];
	timer_resp_t got, want;
	int n_err, n_chk;

	function automatic logic [TIME_BITS-1:0] sat_add(logic [TIME_BITS-1:0] base,
			logic [WAIT_W-1:0] d);
		if (d > (TIME_TOP - base))
			return TIME_TOP;
		return base + d;
	endfunction

	function automatic logic drop_id(logic [ID_W-1:0] id);
		logic hit;
		hit = 1'b0;
		if (id != '0) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (t_busy[i] && t_id[i] == id) begin
					t_busy[i] = 1'b0;
					hit = 1'b1;
				end
			end
		end
		return hit;
	endfunction

	// -1 on an empty table, else smallest time to go, clamped to [0, 2^31-1]
	function automatic logic [31:0] poll_timeout(logic [TIME_BITS-1:0] mono,
			logic [TIME_BITS-1:0] boot);
		logic [TIME_BITS-1:0] now, rem, best;
		logic found;
		found = 1'b0;
		best = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (t_busy[i]) begin
				now = t_boot[i] ? boot : mono;
				rem = (t_deadline[i] > now) ? t_deadline[i] - now : '0;
				if (rem > WAIT_CAP)
					rem = WAIT_CAP;
				if (!found || rem < best)
					best = rem;
				found = 1'b1;
			end
		end
		return found ? best[31:0] : 32'hFFFF_FFFF;
	endfunction

	function automatic void queue_resp(rsp_kind_t kind, logic [31:0] id, logic ok,
			logic active, logic [31:0] wait_ms, logic last);
		timer_resp_t r;
		r.kind = kind;
		r.id = id;
		r.ok = ok;
		r.active = active;
		r.wait_ms = wait_ms;
		r.last = last;
		resp_q = {resp_q, r};
	endfunction

	task automatic model_request(input req_kind_t req, input logic [167:0] d);
		logic [ID_W-1:0]      tid, nid;
		logic [WAIT_W-1:0]    delay;
		logic                 per, on_boot, hnd, act;
		logic [TIME_BITS-1:0] mono, boot, now;
		int                   slot;
		tid = d[31:0];
		delay = d[63] ? '0 : d[62:32];
		per = d[64];
		on_boot = d[65];
		hnd = d[66];
		mono = d[114:67];
		boot = d[162:115];
		nid = '0;
		slot = -1;
		case (req)
			REQ_START: begin
				void'(drop_id(tid));
				if (hnd) begin
					nid = id_next;
					void'(drop_id(nid));
					for (int i = NUM_SLOTS - 1; i >= 0; i--)
						if (!t_busy[i])
							slot = i;
				end
				if (slot < 0) begin
					queue_resp(RSP_START, '0, 1'b0, 1'b0, '0, 1'b1);
				end else begin
					t_busy[slot] = 1'b1;
					t_id[slot] = nid;
					t_boot[slot] = on_boot;
					t_interval[slot] = delay;
					t_rearm[slot] = per;
					t_deadline[slot] = sat_add(on_boot ? boot : mono, delay);
					id_next = (nid == '1) ? 32'd1 : nid + 32'd1;
					queue_resp(RSP_START, nid, 1'b1, 1'b0, '0, 1'b1);
				end
			end
			REQ_CANCEL: begin
				act = drop_id(tid);
				queue_resp(RSP_CANCEL, tid, act, 1'b0, '0, 1'b1);
			end
			REQ_TICK: begin
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (t_busy[i]) begin
						now = t_boot[i] ? boot : mono;
						if (t_deadline[i] <= now) begin
							queue_resp(RSP_FIRED, t_id[i], 1'b0, 1'b0, '0, 1'b0);
							if (t_rearm[i])
								t_deadline[i] = sat_add(now, t_interval[i]);
							else
								t_busy[i] = 1'b0;
						end
					end
				end
				queue_resp(RSP_TICK, '0, 1'b0, 1'b0, poll_timeout(mono, boot), 1'b1);
			end
			default: begin
				act = 1'b0;
				if (tid != '0)
					for (int i = 0; i < NUM_SLOTS; i++)
						if (t_busy[i] && t_id[i] == tid)
							act = 1'b1;
				queue_resp(RSP_QUERY, tid, 1'b0, act, poll_timeout(mono, boot), 1'b1);
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++)
				t_busy[i] = 1'b0;
			id_next = 32'd1;
			resp_q.delete();
			n_err = 0;
			n_chk = 0;
			errors <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			// results of a request never leave on its own transfer edge
			if (m_tvalid && m_tready) begin
				got.kind = rsp_kind_t'(m_tuser);
				got.id = m_tdata[31:0];
				got.ok = m_tdata[32];
				got.active = m_tdata[33];
				got.wait_ms = m_tdata[65:34];
				got.last = m_tlast;
				if (resp_q.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("unexpected result: kind %0d id %h ok %b act %b wait %0d last %b",
							got.kind, got.id, got.ok, got.active, $signed(got.wait_ms),
							got.last);
				end else begin
					want = resp_q.pop_front();
					n_chk++;
					if (got.kind !== want.kind || got.id !== want.id || got.ok !== want.ok ||
							got.active !== want.active || got.wait_ms !== want.wait_ms ||
							got.last !== want.last) begin
						n_err++;
						if (n_err <= 10) begin
							$display("mismatch exp: kind %0d id %h ok %b act %b wait %0d last %b",
								want.kind, want.id, want.ok, want.active,
								$signed(want.wait_ms), want.last);
							$display("         got: kind %0d id %h ok %b act %b wait %0d last %b",
								got.kind, got.id, got.ok, got.active,
								$signed(got.wait_ms), got.last);
						end
					end
				end
			end
			if (s_tvalid && s_tready)
				model_request(req_kind_t'(s_tuser), s_tdata);
			errors <= n_err;
			pending <= resp_q.size();
			checked <= n_chk;
		end
	end

endmodule

[sim/timer_table_engine_tb.sv]
// Testbench top for the timer table engine: clock, reset, request stimulus and
// sink backpressure; checking is done by timer_table_engine_checker.
// Depends on tte_pkg, timer_table_engine and timer_table_engine_checker.
module timer_table_engine_tb;
	import tte_pkg::*;

	localparam int NUM_SLOTS   = 16;
	localparam int RAND_ITEMS  = 351;
	localparam int CALM_ITEMS  = 40;
	localparam int LONG_HOLD   = 400;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [TIME_BITS-1:0] TIME_TOP = '1;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [167:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [71:0]  m_tdata;
	logic [2:0]   m_tuser;
	logic         m_tlast;

	int errors, pending, checked;
	int n_sent, n_fired, cycle_count;
	logic calm, hold_req;
	logic [ID_W-1:0]      live_ids [$];
	logic [TIME_BITS-1:0] mono_t, boot_t;

	timer_table_engine #(.NUM_SLOTS(NUM_SLOTS)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	timer_table_engine_checker #(.NUM_SLOTS(NUM_SLOTS)) chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast), .errors(errors), .pending(pending), .checked(checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// handshake lines are stable mid-cycle, so the coming transfer is seen here
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (rsp_kind_t'(m_tuser) == RSP_START && m_tdata[32]) begin
				live_ids = {live_ids, m_tdata[31:0]};
				if (live_ids.size() > 32)
					void'(live_ids.pop_front());
			end
			if (rsp_kind_t'(m_tuser) == RSP_FIRED)
				n_fired++;
		end
	end

	task automatic send(input req_kind_t req, input logic [31:0] tid, input logic [31:0] dly,
			input logic per, input logic on_boot, input logic hnd,
			input logic [TIME_BITS-1:0] mono, input logic [TIME_BITS-1:0] boot);
		s_tuser <= req;
		s_tdata <= {5'b0, boot, mono, hnd, on_boot, per, dly, tid};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		n_sent++;
	endtask

	// sink: short random stalls, one long hold-off to back up the engine
	initial begin : sink
		logic held;
		held = 1'b0;
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req && !held) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat (calm ? 1 : $urandom_range(1, 10)) @(posedge clk);
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stim
		int r;
		req_kind_t req;
		logic [31:0] tid, dly;
		logic [63:0] wide;
		logic [TIME_BITS-1:0] mono, boot;
		logic [TIME_BITS-1:0] step;

		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= REQ_START;
		calm = 1'b0;
		hold_req = 1'b0;
		n_sent = 0;
		n_fired = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, failed starts, clamping, saturation, full table
		mono_t = 48'd1000;
		boot_t = 48'd5000;
		send(REQ_QUERY, '0, '0, 1'b0, 1'b0, 1'b0, mono_t, boot_t);
		send(REQ_TICK, '0, '0, 1'b0, 1'b0, 1'b0, mono_t, boot_t);
		send(REQ_START, $urandom, 32'd10, 1'b1, 1'b1, 1'b0, mono_t, boot_t);
		send(REQ_START, '0, 32'h8000_0000, 1'b0, 1'b0, 1'b1, mono_t, boot_t);
		send(REQ_START, '0, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1, mono_t, TIME_TOP - 48'd100);
		send(REQ_START, '0, '0, 1'b1, 1'b0, 1'b1, mono_t, boot_t);
		mono_t = mono_t + 48'd1;
		send(REQ_TICK, '0, '0, 1'b0, 1'b0, 1'b0, mono_t, boot_t);
		send(REQ_QUERY, 32'd2, '0, 1'b0, 1'b0, 1'b0, mono_t, boot_t);
		send(REQ_CANCEL, '0, '0, 1'b0, 1'b0, 1'b0, mono_t, boot_t);
		send(REQ_CANCEL, 32'd3, '0, 1'b0, 1'b0, 1'b0, mono_t, boot_t);
		send(REQ_CANCEL, 32'd3, '0, 1'b0, 1'b0, 1'b0, mono_t, boot_t);
		repeat (15)
			send(REQ_START, '0, $urandom_range(1000, 5000), 1'b0, 1'($urandom_range(0, 1)),
				1'b1, mono_t, boot_t);
		send(REQ_START, '0, 32'd50, 1'b0, 1'b0, 1'b1, mono_t, boot_t);
		// replacing a live id frees its slot first
		send(REQ_START, 32'd2, 32'd5, 1'b1, 1'b0, 1'b1, mono_t, boot_t);
		// every slot due at once
		send(REQ_TICK, '0, '0, 1'b0, 1'b0, 1'b0, TIME_TOP, TIME_TOP);

		for (int k = 0; k < RAND_ITEMS; k++) begin
			calm = (k >= RAND_ITEMS - CALM_ITEMS);
			if (k == 80)
				hold_req = 1'b1;
			if (!calm && $urandom_range(0, 4) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end

			r = $urandom_range(0, 99);
			req = (r < 35) ? REQ_START : (r < 50) ? REQ_CANCEL : (r < 85) ? REQ_TICK : REQ_QUERY;

			r = $urandom_range(0, 9);
			if (r < 4 || (r < 8 && live_ids.size() == 0))
				tid = '0;
			else if (r < 8)
				tid = live_ids[$urandom_range(0, live_ids.size() - 1)];
			else
				tid = $urandom;

			r = $urandom_range(0, 9);
			if (r < 7)
				dly = $urandom_range(0, 300);
			else if (r == 7)
				dly = '0;
			else if (r == 8)
				dly = $urandom;
			else
				dly = {1'b1, 31'($urandom)};

			if ($urandom_range(0, 19) == 0) begin
				wide = {$urandom, $urandom};
				mono = wide[TIME_BITS-1:0];
				wide = {$urandom, $urandom};
				boot = wide[TIME_BITS-1:0];
			end else begin
				step = TIME_BITS'($urandom_range(0, 100));
				mono_t = mono_t + step;
				boot_t = boot_t + step + TIME_BITS'($urandom_range(0, 20));
				mono = mono_t;
				boot = boot_t;
			end

			send(req, tid, dly, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 9) != 0), mono, boot);
		end
		s_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		$display("sent %0d requests; %0d timer expiries among %0d compared results",
			n_sent, n_fired, checked);
		$display("mismatches: %0d, results still owed: %0d", errors, pending);
		if (errors == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
